/* rtl/silu_pkg.sv */
package silu_pkg;

    // Field and datapath widths.
    localparam int SMP_W  = 16;          // Q4.12 sample and result
    localparam int FRAC_W = 12;          // fraction bits of Q4.12
    localparam int Q30_SH = 30;          // binary point of the Q2.30 datapath
    localparam int Q_W    = 31;          // unsigned Q2.30 value in 0 .. 1.0
    localparam int SUM_W  = 33;          // signed partial sum of the series
    localparam int DEN_W  = 32;          // 1.0 + exp(-t), up to 2.0
    localparam int NUM_W  = 47;          // dividend, below 2^46
    localparam int QUO_W  = 16;          // quotient magnitude
    localparam int REM_W  = 33;          // divider partial remainder
    localparam int TERMS  = 15;          // terms of the exp(-u) series
    localparam int RCP_W  = 32;          // reciprocal multiplier width

    localparam logic [63:0] ONE_Q30  = 64'd1 << Q30_SH;
    localparam logic [63:0] HALF_Q30 = 64'd1 << (Q30_SH - 1);

    // Exact division of a value below 2^31 by a small constant k:
    // q = (v * RECIP_M[k]) >> RECIP_S[k], with S = 31 + ceil(log2(k)) and
    // M = ceil(2^S / k). Entry zero is unused.
    localparam int RECIP_S [16] = '{
        0, 31, 32, 33, 33, 34, 34, 34, 34, 35, 35, 35, 35, 35, 35, 35
    };

    localparam logic [RCP_W-1:0] RECIP_M [16] = '{
        32'd0,
        32'(((64'd1 << 31) + 64'd0) / 64'd1),
        32'(((64'd1 << 32) + 64'd1) / 64'd2),
        32'(((64'd1 << 33) + 64'd2) / 64'd3),
        32'(((64'd1 << 33) + 64'd3) / 64'd4),
        32'(((64'd1 << 34) + 64'd4) / 64'd5),
        32'(((64'd1 << 34) + 64'd5) / 64'd6),
        32'(((64'd1 << 34) + 64'd6) / 64'd7),
        32'(((64'd1 << 34) + 64'd7) / 64'd8),
        32'(((64'd1 << 35) + 64'd8) / 64'd9),
        32'(((64'd1 << 35) + 64'd9) / 64'd10),
        32'(((64'd1 << 35) + 64'd10) / 64'd11),
        32'(((64'd1 << 35) + 64'd11) / 64'd12),
        32'(((64'd1 << 35) + 64'd12) / 64'd13),
        32'(((64'd1 << 35) + 64'd13) / 64'd14),
        32'(((64'd1 << 35) + 64'd14) / 64'd15)
    };

    // Truncated alternating series for exp(-u), u in Q2.30. Evaluated at
    // elaboration only.
    function automatic logic [63:0] expneg_q30(input logic [63:0] u);
        logic [63:0] term;
        logic [63:0] prod;
        longint      sum;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        for (int k = 1; k <= TERMS; k++) begin
            prod = (term * u) >> Q30_SH;
            term = (prod * 64'(RECIP_M[k])) >> RECIP_S[k];
            if ((k % 2) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return 64'(sum);
    endfunction

    localparam logic [63:0] E1_Q30 = expneg_q30(ONE_Q30);

    // exp(-1) raised to the n-th power with rounding after each step.
    function automatic logic [Q_W-1:0] p_pow(input int n);
        logic [63:0] p;
        p = ONE_Q30;
        for (int i = 0; i < 8; i++) begin
            if (i < n) begin
                p = (p * E1_Q30 + HALF_Q30) >> Q30_SH;
            end
        end
        return Q_W'(p);
    endfunction

    // Integer part of |x| selects exp(-n). Codes above eight never occur.
    localparam logic [Q_W-1:0] P_TAB [16] = '{
        p_pow(0), p_pow(1), p_pow(2), p_pow(3), p_pow(4),
        p_pow(5), p_pow(6), p_pow(7), p_pow(8),
        31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0
    };

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    last_in;
    } t_in;

    typedef struct packed {
        logic signed [SMP_W-1:0] result;
        logic                    last_out;
    } t_out;

    // Per-item data that rides along the pipeline.
    typedef struct packed {
        logic             neg;
        logic [SMP_W-1:0] mag;
        logic             last;
    } t_side;

endpackage

/* rtl/silu_expneg.sv */
module silu_expneg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  silu_pkg::t_side        i_side,
    output logic                   o_valid,
    output logic [silu_pkg::Q_W-1:0] o_ef,
    output silu_pkg::t_side        o_side
);
    import silu_pkg::*;

    localparam int MULA_W = Q_W + FRAC_W;
    localparam int MULB_W = Q_W + RCP_W;

    // Each series term takes two stages: the product term * u, then the
    // exact division by k. The running sum absorbs the previous term in the
    // same stage as the next product.
    logic [TERMS:1]                r_a_valid;
    logic [Q_W-1:0]                r_prod    [1:TERMS];
    logic signed [SUM_W-1:0]       r_a_sum   [1:TERMS];
    t_side                         r_a_side  [1:TERMS];
    logic [TERMS:1]                r_b_valid;
    logic [Q_W-1:0]                r_term    [1:TERMS];
    logic signed [SUM_W-1:0]       r_b_sum   [1:TERMS];
    t_side                         r_b_side  [1:TERMS];
    logic                          r_valid;
    logic [Q_W-1:0]                r_ef;
    t_side                         r_side;

    logic [Q_W-1:0]                n_prod    [1:TERMS];
    logic signed [SUM_W-1:0]       n_a_sum   [1:TERMS];
    logic [Q_W-1:0]                n_term    [1:TERMS];
    logic signed [SUM_W-1:0]       n_sum_fin;
    logic [Q_W-1:0]                n_ef;

    always_comb begin
        n_prod[1]  = Q_W'((MULA_W'(Q_W'(ONE_Q30)) * MULA_W'(i_side.mag[FRAC_W-1:0]))
                          >> FRAC_W);
        n_a_sum[1] = SUM_W'(ONE_Q30);
        for (int k = 2; k <= TERMS; k++) begin
            n_prod[k] = Q_W'((MULA_W'(r_term[k-1]) * MULA_W'(r_b_side[k-1].mag[FRAC_W-1:0]))
                             >> FRAC_W);
            if ((k % 2) == 0) begin
                n_a_sum[k] = r_b_sum[k-1] - $signed(SUM_W'(r_term[k-1]));
            end else begin
                n_a_sum[k] = r_b_sum[k-1] + $signed(SUM_W'(r_term[k-1]));
            end
        end
        for (int k = 1; k <= TERMS; k++) begin
            n_term[k] = Q_W'((MULB_W'(r_prod[k]) * MULB_W'(RECIP_M[k])) >> RECIP_S[k]);
        end
        if ((TERMS % 2) != 0) begin
            n_sum_fin = r_b_sum[TERMS] - $signed(SUM_W'(r_term[TERMS]));
        end else begin
            n_sum_fin = r_b_sum[TERMS] + $signed(SUM_W'(r_term[TERMS]));
        end
        n_ef = (n_sum_fin < 0) ? '0 : Q_W'(n_sum_fin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= '0;
            r_b_valid <= '0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= {r_b_valid[TERMS-1:1], i_valid};
            r_b_valid <= r_a_valid;
            r_valid   <= r_b_valid[TERMS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side[1] <= i_side;
            for (int k = 2; k <= TERMS; k++) begin
                r_a_side[k] <= r_b_side[k-1];
            end
            for (int k = 1; k <= TERMS; k++) begin
                r_prod[k]   <= n_prod[k];
                r_a_sum[k]  <= n_a_sum[k];
                r_term[k]   <= n_term[k];
                r_b_sum[k]  <= r_a_sum[k];
                r_b_side[k] <= r_a_side[k];
            end
            r_ef   <= n_ef;
            r_side <= r_b_side[TERMS];
        end
    end

    assign o_valid = r_valid;
    assign o_ef    = r_ef;
    assign o_side  = r_side;

endmodule

/* rtl/silu_div.sv */
module silu_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [silu_pkg::NUM_W-1:0] i_num,
    input  logic [silu_pkg::DEN_W-1:0] i_den,
    input  silu_pkg::t_side            i_side,
    output logic                       o_valid,
    output logic [silu_pkg::QUO_W-1:0] o_quo,
    output silu_pkg::t_side            o_side
);
    import silu_pkg::*;

    // Restoring division, one quotient bit per stage, most significant first.
    // The dividend is below den * 2^QUO_W, so its upper part starts below den.
    logic [QUO_W:1]       r_valid;
    logic [REM_W-1:0]     r_rem  [1:QUO_W];
    logic [QUO_W-1:0]     r_quo  [1:QUO_W];
    logic [NUM_W-1:0]     r_num  [1:QUO_W];
    logic [DEN_W-1:0]     r_den  [1:QUO_W];
    t_side                r_side [1:QUO_W];

    logic [REM_W-1:0]     rem_in [1:QUO_W];
    logic [QUO_W-1:0]     quo_in [1:QUO_W];
    logic [REM_W-1:0]     trial  [1:QUO_W];
    logic [DEN_W-1:0]     den_in [1:QUO_W];
    logic [NUM_W-1:0]     num_in [1:QUO_W];
    logic [QUO_W:1]       fits;
    logic [REM_W-1:0]     n_rem  [1:QUO_W];
    logic [QUO_W-1:0]     n_quo  [1:QUO_W];

    always_comb begin
        rem_in[1] = REM_W'(i_num >> QUO_W);
        quo_in[1] = '0;
        num_in[1] = i_num;
        den_in[1] = i_den;
        for (int s = 2; s <= QUO_W; s++) begin
            rem_in[s] = r_rem[s-1];
            quo_in[s] = r_quo[s-1];
            num_in[s] = r_num[s-1];
            den_in[s] = r_den[s-1];
        end
        for (int s = 1; s <= QUO_W; s++) begin
            trial[s]  = {rem_in[s][REM_W-2:0], num_in[s][QUO_W-s]};
            fits[s]   = trial[s] >= REM_W'(den_in[s]);
            n_rem[s]  = fits[s] ? (trial[s] - REM_W'(den_in[s])) : trial[s];
            n_quo[s]  = {quo_in[s][QUO_W-2:0], fits[s]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QUO_W-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[1] <= i_side;
            for (int s = 2; s <= QUO_W; s++) begin
                r_side[s] <= r_side[s-1];
            end
            for (int s = 1; s <= QUO_W; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_num[s] <= num_in[s];
                r_den[s] <= den_in[s];
            end
        end
    end

    assign o_valid = r_valid[QUO_W];
    assign o_quo   = r_quo[QUO_W];
    assign o_side  = r_side[QUO_W];

endmodule

/* rtl/silu_skid.sv */
module silu_skid (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  silu_pkg::t_out i_data,
    output logic           o_ready,
    output logic           o_valid,
    output silu_pkg::t_out o_data,
    input  logic           i_ready
);
    import silu_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_out r_out;
    t_out r_skid;
    logic out_free;
    logic take;

    // Ready upstream depends only on the spare register, so the pipeline
    // enable is a flop output.
    assign o_ready  = ~r_skid_valid;
    assign out_free = ~r_out_valid | i_ready;
    assign take     = i_valid & ~r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid | take;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (take) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* rtl/silu_activation_top.sv */
// SiLU (swish) activation: result = x * sigmoid(x) = x / (1 + exp(-x)).
// Input beats carry a signed Q4.12 sample and a last flag; each one yields
// exactly one output beat with the Q4.12 result, rounded to nearest with ties
// away from zero, and the same last flag. Both channels use valid/ready.
// Throughput is one beat per clock cycle while no output stall freezes the
// pipeline. Its depth is set by the exp(-frac) series, fifteen terms at two
// stages each, and by the sixteen-stage restoring divider that forms the
// quotient. exp(-int) comes from a nine-entry constant table and costs one
// stage.
// The block keeps no state between beats; reset clears only the valid bits
// of the pipeline and the output buffer, so no beat is in flight after it.
// When the receiver stalls, the output register holds its beat and one more
// result drops into a spare register; only then does the whole pipeline
// freeze and input ready fall, so nothing is lost or repeated, and input is
// accepted as usual while a single finished result waits to be taken.
module silu_activation_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  silu_pkg::t_in i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output silu_pkg::t_out o_data
);
    import silu_pkg::*;

    localparam int MULE_W = 2 * Q_W;

    // Global advance for every pipeline stage.
    logic pipe_en;

    // Stage 0: magnitude and sign of the sample.
    logic  r_in_valid;
    t_side r_in_side;
    t_side n_in_side;

    always_comb begin
        n_in_side.neg  = i_data.sample[SMP_W-1];
        n_in_side.mag  = i_data.sample[SMP_W-1] ? (~i_data.sample + SMP_W'(1))
                                                : i_data.sample;
        n_in_side.last = i_data.last_in;
    end

    // Series for exp(-frac(t)).
    logic           ef_valid;
    logic [Q_W-1:0] ef;
    t_side          ef_side;

    silu_expneg u_expneg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_in_valid),
        .i_side  (r_in_side),
        .o_valid (ef_valid),
        .o_ef    (ef),
        .o_side  (ef_side)
    );

    // Stage E: e = exp(-frac) * exp(-int), rounded.
    logic           r_e_valid;
    logic [Q_W-1:0] r_e;
    t_side          r_e_side;
    logic [Q_W-1:0] n_e;

    assign n_e = Q_W'((MULE_W'(ef) * MULE_W'(P_TAB[ef_side.mag[SMP_W-1:FRAC_W]])
                       + MULE_W'(HALF_Q30)) >> Q30_SH);

    // Stage N: denominator and rounded dividend. A positive sample divides
    // x itself, a negative one divides |x| * e.
    logic             r_n_valid;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    t_side            r_n_side;
    logic [DEN_W-1:0] n_den;
    logic [NUM_W-1:0] n_num;

    always_comb begin
        n_den = DEN_W'(ONE_Q30) + DEN_W'(r_e);
        if (r_e_side.neg) begin
            n_num = NUM_W'(r_e_side.mag) * NUM_W'(r_e) + NUM_W'(n_den >> 1);
        end else begin
            n_num = (NUM_W'(r_e_side.mag) << Q30_SH) + NUM_W'(n_den >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_e_valid  <= 1'b0;
            r_n_valid  <= 1'b0;
        end else if (pipe_en) begin
            r_in_valid <= i_valid;
            r_e_valid  <= ef_valid;
            r_n_valid  <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_in_side <= n_in_side;
            r_e       <= n_e;
            r_e_side  <= ef_side;
            r_num     <= n_num;
            r_den     <= n_den;
            r_n_side  <= r_e_side;
        end
    end

    // Rounded quotient magnitude.
    logic             quo_valid;
    logic [QUO_W-1:0] quo;
    t_side            quo_side;

    silu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_n_valid),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_n_side),
        .o_valid (quo_valid),
        .o_quo   (quo),
        .o_side  (quo_side)
    );

    // Restore the sign and hand the beat to the output buffer.
    t_out res_beat;

    always_comb begin
        res_beat.result   = quo_side.neg ? $signed(SMP_W'(~quo + QUO_W'(1)))
                                         : $signed(SMP_W'(quo));
        res_beat.last_out = quo_side.last;
    end

    silu_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (quo_valid),
        .i_data  (res_beat),
        .o_ready (pipe_en),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (i_ready)
    );

    assign o_ready = pipe_en;

endmodule

/* tb/tb_silu_activation_top.sv */
module tb_silu_activation_top;

    // Q2.30 unity and its rounding half, as used by the fixed-point SiLU recipe.
    localparam logic [63:0] UNIT_Q30  = 64'd1 << 30;
    localparam logic [63:0] ROUND_Q30 = 64'd1 << 29;
    localparam int          SERIES_N  = 15;

    // The drain wait runs on after the last expected result so that any stray
    // result still in the pipeline shows up.
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 1500;

    // The receiver holds off once for this many cycles, after this many results.
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 500;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    silu_pkg::t_in        i_data  = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    silu_pkg::t_out       o_data;

    // Beats waiting to be offered, and results owed by the block, oldest first.
    silu_pkg::t_in        pending_samples[$];
    silu_pkg::t_out       expected_silu[$];

    int                   sent_beats     = 0;
    int                   rx_beats       = 0;
    int                   neg_beats      = 0;
    int                   last_beats     = 0;
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;

    silu_activation_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Period of 12 time units: high for 6, low for 6.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // exp(-u) for u in Q2.30 between zero and one, from a truncated alternating
    // power series. Each term is truncated after the multiply and the divide.
    function automatic logic [63:0] exp_neg_taylor_q30(input logic [63:0] u);
        logic [63:0] term;
        longint      acc;
        term = UNIT_Q30;
        acc  = longint'(UNIT_Q30);
        for (int k = 1; k <= SERIES_N; k++) begin
            term = ((term * u) >> 30) / 64'(k);
            if ((k % 2) != 0) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return 64'(acc);
    endfunction

    // Expected SiLU output for one input beat. |x| is split into an integer
    // part, whose exp(-n) is built by repeated rounded products of exp(-1),
    // and a 12-bit fraction that goes through the series directly.
    function automatic silu_pkg::t_out silu_q412_predict(input silu_pkg::t_in beat);
        logic [63:0]    raw;
        logic [63:0]    abs_x;
        logic [63:0]    int_part;
        logic [63:0]    frac_part;
        logic [63:0]    e_one;
        logic [63:0]    e_frac;
        logic [63:0]    e_int;
        logic [63:0]    e_all;
        logic [63:0]    den;
        logic [63:0]    quo;
        logic           neg;
        silu_pkg::t_out res;
        raw       = {48'd0, beat.sample};
        neg       = raw[15];
        abs_x     = neg ? (64'h10000 - raw) : raw;
        int_part  = abs_x >> 12;
        frac_part = abs_x & 64'hFFF;
        e_one     = exp_neg_taylor_q30(UNIT_Q30);
        e_frac    = exp_neg_taylor_q30(frac_part << 18);
        e_int     = UNIT_Q30;
        for (int i = 0; i < 8; i++) begin
            if (i < int_part) begin
                e_int = (e_int * e_one + ROUND_Q30) >> 30;
            end
        end
        e_all = (e_frac * e_int + ROUND_Q30) >> 30;
        den   = UNIT_Q30 + e_all;
        if (!neg) begin
            quo        = ((abs_x << 30) + (den >> 1)) / den;
            res.result = quo[15:0];
        end else begin
            // Negative x: x * sigmoid(x) = -(|x| * exp(-|x|)) / (1 + exp(-|x|)).
            quo        = (abs_x * e_all + (den >> 1)) / den;
            res.result = 16'(64'd0 - quo);
        end
        res.last_out = beat.last_in;
        return res;
    endfunction

    task automatic queue_sample(input logic [15:0] value, input logic last);
        silu_pkg::t_in beat;
        beat.sample  = value;
        beat.last_in = last;
        pending_samples.push_back(beat);
    endtask

    // Random sample with a bias toward the interesting regions: the integer
    // boundaries of |x|, small magnitudes, and the full 16-bit range.
    function automatic logic [15:0] random_sample();
        logic [15:0] mag;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            return 16'($urandom());
        end else if (pick < 7) begin
            mag = 16'($urandom_range(0, 7) * 4096 + $urandom_range(0, 3))
                - 16'($urandom_range(0, 3));
        end else begin
            mag = 16'($urandom_range(0, 4095));
        end
        return $urandom_range(0, 1) ? (16'd0 - mag) : mag;
    endfunction

    // Stimulus, reset and end of run.
    initial begin
        int          arr_len;
        int          total;
        logic [15:0] val;

        // Directed beats: zero, the smallest steps, both extremes of the field,
        // whole values where the fraction is zero, the largest fraction, and
        // the most negative sample, which has an integer part of eight.
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'h0001, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h7FFF, 1'b1);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h8001, 1'b0);
        queue_sample(16'h1000, 1'b0);
        queue_sample(16'hF000, 1'b1);
        queue_sample(16'h0FFF, 1'b0);
        queue_sample(16'hF001, 1'b0);
        queue_sample(16'h2000, 1'b0);
        queue_sample(16'hE000, 1'b0);
        queue_sample(16'h7000, 1'b0);
        queue_sample(16'h9000, 1'b1);
        queue_sample(16'h5555, 1'b0);
        queue_sample(16'hAAAA, 1'b1);
        queue_sample(16'h0800, 1'b0);
        queue_sample(16'hF800, 1'b0);
        queue_sample(16'h6FFF, 1'b0);
        queue_sample(16'h9001, 1'b1);

        // Random part: arrays of random length, each closed by a last flag.
        // Roughly one array in eight is left unterminated to cover a flag that
        // stays low across an array boundary.
        total = 0;
        while (total < RANDOM_BEATS) begin
            arr_len = $urandom_range(1, 24);
            for (int j = 0; j < arr_len; j++) begin
                val = random_sample();
                queue_sample(val, (j == arr_len - 1) && ($urandom_range(0, 7) != 0));
            end
            total += arr_len;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every beat has been offered, taken and answered.
        while (pending_samples.size() != 0 || i_valid || expected_silu.size() != 0) begin
            @(posedge i_clk);
        end
        // Any result that shows up now has no expectation and is flagged.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d samples (%0d negative, %0d array ends), %0d results",
                 sent_beats, neg_beats, last_beats, rx_beats);
        $display("checked under bursty input, output stalls and one long hold-off.");
        if (mismatch_count == 0 && expected_silu.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Mismatches: %0d, results still owed: %0d",
                     mismatch_count, expected_silu.size());
            $display("Regression FAIL");
        end
        $finish;
    end

    // Driver: offers beats in bursts of random length with random gaps. A beat
    // stays on the bus unchanged until it is taken.
    always @(posedge i_clk) begin
        int            burst_left;
        int            gap_left;
        logic          next_valid;
        silu_pkg::t_in next_beat;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = $urandom_range(1, 64);
            gap_left   = 0;
        end else begin
            if (i_valid && o_ready) begin
                expected_silu.push_back(silu_q412_predict(i_data));
                sent_beats++;
                if (i_data.sample[15]) begin
                    neg_beats++;
                end
                if (i_data.last_in) begin
                    last_beats++;
                end
            end
            if (!i_valid || o_ready) begin
                next_valid = 1'b0;
                next_beat  = i_data;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_samples.size() != 0) begin
                    next_beat  = pending_samples.pop_front();
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 64);
                        // About a third of the bursts run straight into the next one.
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                i_valid <= next_valid;
                i_data  <= next_beat;
            end
        end
    end

    // Receiver: the ready pattern is redrawn periodically among always ready,
    // coin flip, a fixed one-in-five stall and a mostly stalled mode. Once,
    // after enough results, it holds off long enough for the pipeline to fill
    // and push back on the input.
    always @(posedge i_clk) begin
        int mode;
        int mode_cycles;
        int hold_left;
        bit hold_done;
        if (!i_rst_n) begin
            i_ready     <= 1'b0;
            mode        = 0;
            mode_cycles = 0;
            hold_left   = 0;
            hold_done   = 1'b0;
        end else begin
            if (!hold_done && rx_beats >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            mode_cycles++;
            if (mode_cycles >= 256) begin
                mode_cycles = 0;
                mode        = $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0: begin
                        i_ready <= 1'b1;
                    end
                    1: begin
                        i_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        i_ready <= (mode_cycles % 5) != 0;
                    end
                    default: begin
                        i_ready <= $urandom_range(0, 4) == 0;
                    end
                endcase
            end
        end
    end

    // Monitor: every result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin
        silu_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            rx_beats++;
            if (expected_silu.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result beat: result=%0d last=%0b",
                             o_data.result, o_data.last_out);
                end
            end else begin
                want = expected_silu.pop_front();
                if (o_data.result !== want.result || o_data.last_out !== want.last_out) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Result beat %0d: result exp %0d got %0d, last exp %0b got %0b",
                                 rx_beats, want.result, o_data.result,
                                 want.last_out, o_data.last_out);
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, expected_silu.size());
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
